>>> src/sample_table_offset_resolver_unit_assert.svh
// assertion macros for the offset resolver
`ifndef SAMPLE_TABLE_OFFSET_RESOLVER_UNIT_ASSERT_SVH
`define SAMPLE_TABLE_OFFSET_RESOLVER_UNIT_ASSERT_SVH

// property checked on every clock edge outside reset
`define STOR_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("stor assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define STOR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("stor assertion failed");

`endif

>>> src/stor_pkg.sv
`default_nettype none
package stor_pkg;

  localparam int unsigned MaxMapEntries = 256;
  localparam int unsigned MaxChunks     = 4096;
  localparam int unsigned MaxSamples    = 16384;

  localparam int unsigned EntW  = 10;
  localparam int unsigned ChkW  = 14;
  localparam int unsigned SmpW  = 16;

  typedef enum logic [1:0] {
    CMD_WR_MAP   = 2'd0,
    CMD_WR_CHUNK = 2'd1,
    CMD_WR_SIZE  = 2'd2,
    CMD_LOOKUP   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_BAD_SPC   = 3'd2,
    ST_OUTSIDE   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    REG_DEFAULT_SIZE  = 3'd0,
    REG_TOTAL_SAMPLES = 3'd1,
    REG_MAP_ENTRIES   = 3'd2,
    REG_TOTAL_CHUNKS  = 3'd3,
    REG_MOVIE_BYTES   = 3'd4
  } reg_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [13:0] slot;
    logic [31:0] first_chunk;
    logic [31:0] chunk_samples;
    logic [63:0] value;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] byte_offset;
    logic [31:0] byte_length;
  } result_t;

  typedef struct packed {
    logic    latch;
    logic    write;
    logic    init;
    logic    scan_step;
    logic    spc_load;
    logic    sz_step;
    logic    next_chunk;
    logic    finish;
    logic    found;
    status_e code;
  } ctrl_t;

  typedef struct packed {
    logic is_write;
    logic wr_ok;
    logic lk_invalid;
    logic no_chunks;
    logic scan_break;
    logic scan_last;
    logic spc_bad;
    logic inner_go;
    logic sz_outside;
    logic sz_hit;
    logic sz_more;
    logic chunk_last;
  } stat_t;

endpackage
`default_nettype wire

>>> src/stor_ram.sv
`default_nettype none
module stor_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> src/stor_ctrl.sv
`default_nettype none
module stor_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire stor_pkg::stat_t stat_i,
  output stor_pkg::ctrl_t     ctrl_o
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DISP     = 9'b000000010,
    S_SCAN     = 9'b000000100,
    S_SCAN_CHK = 9'b000001000,
    S_SPC      = 9'b000010000,
    S_SPC_CHK  = 9'b000100000,
    S_SZ       = 9'b001000000,
    S_SZ_CHK   = 9'b010000000,
    S_NEXT     = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    ctrl_o.code = stor_pkg::ST_OK;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          ctrl_o.latch = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        if (stat_i.is_write) begin
          ctrl_o.write  = 1'b1;
          ctrl_o.finish = 1'b1;
          ctrl_o.code   = stat_i.wr_ok ? stor_pkg::ST_OK : stor_pkg::ST_INVALID;
          state_d = S_IDLE;
        end else if (stat_i.lk_invalid) begin
          ctrl_o.finish = 1'b1;
          ctrl_o.code   = stor_pkg::ST_INVALID;
          state_d = S_IDLE;
        end else if (stat_i.no_chunks) begin
          ctrl_o.finish = 1'b1;
          ctrl_o.code   = stor_pkg::ST_NOT_FOUND;
          state_d = S_IDLE;
        end else begin
          ctrl_o.init = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        ctrl_o.scan_step = 1'b1;
        state_d = (stat_i.scan_break || stat_i.scan_last) ? S_SPC : S_SCAN;
      end
      S_SPC: begin
        state_d = S_SPC_CHK;
      end
      S_SPC_CHK: begin
        if (stat_i.spc_bad) begin
          ctrl_o.finish = 1'b1;
          ctrl_o.code   = stor_pkg::ST_BAD_SPC;
          state_d = S_IDLE;
        end else begin
          ctrl_o.spc_load = 1'b1;
          state_d = stat_i.inner_go ? S_SZ : S_NEXT;
        end
      end
      S_SZ: begin
        state_d = S_SZ_CHK;
      end
      S_SZ_CHK: begin
        if (stat_i.sz_outside) begin
          ctrl_o.finish = 1'b1;
          ctrl_o.code   = stor_pkg::ST_OUTSIDE;
          state_d = S_IDLE;
        end else if (stat_i.sz_hit) begin
          ctrl_o.finish = 1'b1;
          ctrl_o.found  = 1'b1;
          ctrl_o.code   = stor_pkg::ST_OK;
          state_d = S_IDLE;
        end else begin
          ctrl_o.sz_step = 1'b1;
          state_d = stat_i.sz_more ? S_SZ : S_NEXT;
        end
      end
      S_NEXT: begin
        if (stat_i.chunk_last) begin
          ctrl_o.finish = 1'b1;
          ctrl_o.code   = stor_pkg::ST_NOT_FOUND;
          state_d = S_IDLE;
        end else begin
          ctrl_o.next_chunk = 1'b1;
          state_d = S_SCAN;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> src/stor_dp.sv
`default_nettype none
module stor_dp #(
  parameter int unsigned MAX_MAP_ENTRIES = stor_pkg::MaxMapEntries,
  parameter int unsigned MAX_CHUNKS      = stor_pkg::MaxChunks,
  parameter int unsigned MAX_SAMPLES     = stor_pkg::MaxSamples
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire stor_pkg::item_t  item_i,
  input  wire logic             cfg_valid_i,
  input  wire logic [2:0]       cfg_index_i,
  input  wire logic [63:0]      cfg_data_i,
  input  wire stor_pkg::ctrl_t  ctrl_i,
  output stor_pkg::stat_t       stat_o,
  output logic                  done_o,
  output stor_pkg::result_t     result_o
);

  localparam int unsigned MAW = (MAX_MAP_ENTRIES > 1) ? $clog2(MAX_MAP_ENTRIES) : 1;
  localparam int unsigned CAW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int unsigned SAW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

  logic [31:0] dflt_size_q;
  logic [14:0] total_samples_q;
  logic [8:0]  map_entries_q;
  logic [12:0] total_chunks_q;
  logic [47:0] movie_bytes_q;

  stor_pkg::item_t req_q;
  logic [stor_pkg::EntW-1:0] e_q, pick_q;
  logic [stor_pkg::ChkW-1:0] chunk_q;
  logic [stor_pkg::SmpW-1:0] sample_q, within_q;
  logic [31:0] spc_q;
  logic [63:0] pos_q;
  logic        done_q;
  stor_pkg::result_t result_q;

  logic [31:0] fc_rdata, spc_rdata, size_rdata;
  logic [63:0] off_rdata;
  logic [31:0] sz;
  logic [63:0] room;
  logic        in_range;
  logic        we_map, we_chunk, we_size;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_size_q     <= '0;
      total_samples_q <= '0;
      map_entries_q   <= '0;
      total_chunks_q  <= '0;
      movie_bytes_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        stor_pkg::REG_DEFAULT_SIZE:  dflt_size_q     <= cfg_data_i[31:0];
        stor_pkg::REG_TOTAL_SAMPLES: total_samples_q <= cfg_data_i[14:0];
        stor_pkg::REG_MAP_ENTRIES:   map_entries_q   <= cfg_data_i[8:0];
        stor_pkg::REG_TOTAL_CHUNKS:  total_chunks_q  <= cfg_data_i[12:0];
        stor_pkg::REG_MOVIE_BYTES:   movie_bytes_q   <= cfg_data_i[47:0];
        default: ;
      endcase
    end
  end

  // write slot range check per store
  always_comb begin
    case (req_q.cmd)
      stor_pkg::CMD_WR_MAP:   in_range = (32'(req_q.slot) < MAX_MAP_ENTRIES);
      stor_pkg::CMD_WR_CHUNK: in_range = (32'(req_q.slot) < MAX_CHUNKS);
      stor_pkg::CMD_WR_SIZE:  in_range = (32'(req_q.slot) < MAX_SAMPLES);
      default:                in_range = 1'b0;
    endcase
  end

  assign we_map   = ctrl_i.write && in_range && (req_q.cmd == stor_pkg::CMD_WR_MAP);
  assign we_chunk = ctrl_i.write && in_range && (req_q.cmd == stor_pkg::CMD_WR_CHUNK);
  assign we_size  = ctrl_i.write && in_range && (req_q.cmd == stor_pkg::CMD_WR_SIZE);

  stor_ram #(.WIDTH(32), .DEPTH(MAX_MAP_ENTRIES)) u_map_fc (
    .clk_i   (clk_i),
    .we_i    (we_map),
    .waddr_i (MAW'(req_q.slot)),
    .wdata_i (req_q.first_chunk),
    .raddr_i (MAW'(e_q)),
    .rdata_o (fc_rdata)
  );

  stor_ram #(.WIDTH(32), .DEPTH(MAX_MAP_ENTRIES)) u_map_spc (
    .clk_i   (clk_i),
    .we_i    (we_map),
    .waddr_i (MAW'(req_q.slot)),
    .wdata_i (req_q.chunk_samples),
    .raddr_i (MAW'(pick_q)),
    .rdata_o (spc_rdata)
  );

  stor_ram #(.WIDTH(64), .DEPTH(MAX_CHUNKS)) u_chunk_off (
    .clk_i   (clk_i),
    .we_i    (we_chunk),
    .waddr_i (CAW'(req_q.slot)),
    .wdata_i (req_q.value),
    .raddr_i (CAW'(chunk_q - stor_pkg::ChkW'(1))),
    .rdata_o (off_rdata)
  );

  stor_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_size (
    .clk_i   (clk_i),
    .we_i    (we_size),
    .waddr_i (SAW'(req_q.slot)),
    .wdata_i (req_q.value[31:0]),
    .raddr_i (SAW'(sample_q)),
    .rdata_o (size_rdata)
  );

  assign sz   = (dflt_size_q != '0) ? dflt_size_q : size_rdata;
  assign room = {16'b0, movie_bytes_q} - pos_q;

  always_comb begin
    stat_o.is_write   = (req_q.cmd != stor_pkg::CMD_LOOKUP);
    stat_o.wr_ok      = in_range;
    stat_o.lk_invalid = (15'(req_q.slot) >= total_samples_q) || (map_entries_q == '0) ||
                        (32'(map_entries_q) > MAX_MAP_ENTRIES) ||
                        (32'(total_chunks_q) > MAX_CHUNKS) ||
                        (32'(total_samples_q) > MAX_SAMPLES);
    stat_o.no_chunks  = (total_chunks_q == '0);
    stat_o.scan_break = (fc_rdata > 32'(chunk_q));
    stat_o.scan_last  = ((e_q + stor_pkg::EntW'(1)) == stor_pkg::EntW'(map_entries_q));
    stat_o.spc_bad    = (spc_rdata == '0) || (32'(sample_q) > ~spc_rdata);
    stat_o.inner_go   = (sample_q < stor_pkg::SmpW'(total_samples_q));
    stat_o.sz_outside = (pos_q > {16'b0, movie_bytes_q}) || ({32'b0, sz} > room);
    stat_o.sz_hit     = (sample_q == stor_pkg::SmpW'(req_q.slot));
    stat_o.sz_more    = ({17'b0, within_q + stor_pkg::SmpW'(1)} < {1'b0, spc_q}) &&
                        ((sample_q + stor_pkg::SmpW'(1)) < stor_pkg::SmpW'(total_samples_q));
    stat_o.chunk_last = (chunk_q == stor_pkg::ChkW'(total_chunks_q));
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      req_q <= item_i;
    end
    if (ctrl_i.init) begin
      chunk_q  <= stor_pkg::ChkW'(1);
      e_q      <= '0;
      pick_q   <= '0;
      sample_q <= '0;
    end
    if (ctrl_i.scan_step) begin
      if (!stat_o.scan_break) begin
        pick_q <= e_q;
      end
      e_q <= e_q + stor_pkg::EntW'(1);
    end
    if (ctrl_i.spc_load) begin
      spc_q    <= spc_rdata;
      within_q <= '0;
      pos_q    <= off_rdata;
    end
    if (ctrl_i.sz_step) begin
      pos_q    <= pos_q + {32'b0, sz};
      within_q <= within_q + stor_pkg::SmpW'(1);
      sample_q <= sample_q + stor_pkg::SmpW'(1);
    end
    if (ctrl_i.next_chunk) begin
      chunk_q <= chunk_q + stor_pkg::ChkW'(1);
      e_q     <= '0;
      pick_q  <= '0;
    end
    if (ctrl_i.finish) begin
      result_q.status      <= ctrl_i.code;
      result_q.byte_offset <= ctrl_i.found ? pos_q : '0;
      result_q.byte_length <= ctrl_i.found ? sz : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctrl_i.finish;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule
`default_nettype wire

>>> src/sample_table_offset_resolver_unit.sv
// writes and rejected lookups finish in the dispatch state after start
// lookups: per chunk a scan over the map entries, a fetch of the chunk
// offset and samples per chunk, then a walk over the samples
// one item at a time; results come the cycle after the last step, no stall
// reset: asynchronous active low, clears config registers and control state
// table contents are not cleared by reset
`default_nettype none
module sample_table_offset_resolver_unit #(
  parameter int unsigned MAX_MAP_ENTRIES = stor_pkg::MaxMapEntries,
  parameter int unsigned MAX_CHUNKS      = stor_pkg::MaxChunks,
  parameter int unsigned MAX_SAMPLES     = stor_pkg::MaxSamples
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire stor_pkg::item_t   item_i,
  output logic                   done_o,
  output stor_pkg::result_t      result_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [2:0]        cfg_index_i,
  input  wire logic [63:0]       cfg_data_i
);

  stor_pkg::ctrl_t ctrl;
  stor_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  stor_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  stor_dp #(
    .MAX_MAP_ENTRIES (MAX_MAP_ENTRIES),
    .MAX_CHUNKS      (MAX_CHUNKS),
    .MAX_SAMPLES     (MAX_SAMPLES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .done_o      (done_o),
    .result_o    (result_o)
  );

endmodule
`default_nettype wire

>>> src/stor_checker.sv
`default_nettype none
`include "sample_table_offset_resolver_unit_assert.svh"
module stor_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done_o,
  input wire stor_pkg::result_t result_o
);

  `STOR_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `STOR_ASSERT_NEXT(a_done_single, done_o, !done_o)
  `STOR_ASSERT(a_done_idle, done_o |-> !busy)
  `STOR_ASSERT(a_err_zero, (done_o && result_o.status != stor_pkg::ST_OK) |-> (result_o.byte_offset == '0 && result_o.byte_length == '0))

endmodule

bind sample_table_offset_resolver_unit stor_checker u_stor_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);
`default_nettype wire
